// File: design/i2cm_pkg.sv
// Shared types and constants for the I2C register access master.
package i2cm_pkg;

    localparam int TICK_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;

    // Item kinds.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_WAIT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [6:0] SLAVE_ADDR_RST = 7'd104;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd5;
    localparam logic [TICK_W-1:0] ACK_WAIT_RST = 16'd688;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_HI,
        PH_ST_LO,
        PH_BIT_LO,
        PH_BIT_HI,
        PH_ACK_LO,
        PH_ACK_HI,
        PH_ACK_WAIT,
        PH_RS_LO,
        PH_RD_LO,
        PH_RD_HI,
        PH_NK_LO,
        PH_NK_HI,
        PH_SP_LO,
        PH_SP_HI,
        PH_SP_REL
    } phase_t;

    typedef struct packed {
        logic [6:0]        slave_addr;
        logic [TICK_W-1:0] phase_ticks;
        logic [TICK_W-1:0] ack_wait;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [TICK_W-1:0] tick_count;
        logic [3:0]        bit_index;
        logic [1:0]        byte_index;
        logic [7:0]        shift_byte;
        logic [7:0]        reg_latch;
        logic [7:0]        data_latch;
        logic              is_read;
        logic [7:0]        received_byte;
        logic              nack_seen;
    } bus_state_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_error;
        logic       command_rejected;
    } result_t;

    localparam bus_state_t BUS_STATE_RST = '{
        phase: PH_IDLE,
        tick_count: '0,
        bit_index: '0,
        byte_index: '0,
        shift_byte: '0,
        reg_latch: '0,
        data_latch: '0,
        is_read: 1'b0,
        received_byte: '0,
        nack_seen: 1'b0
    };

endpackage

// File: design/i2cm_regs.sv
// Configuration registers written through the configuration write channel.
module i2cm_regs
    import i2cm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_addr <= SLAVE_ADDR_RST;
            cfg_reg.phase_ticks <= PHASE_TICKS_RST;
            cfg_reg.ack_wait <= ACK_WAIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SLAVE_ADDR:  cfg_reg.slave_addr <= cfg_data[6:0];
                CFG_PHASE_TICKS: cfg_reg.phase_ticks <= cfg_data;
                CFG_ACK_WAIT:    cfg_reg.ack_wait <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/i2cm_step.sv
// Next-state and line-drive logic of the bus sequencer for one item.
module i2cm_step
    import i2cm_pkg::*;
(
    input  bus_state_t cur,
    input  cfg_t       cfg,
    input  logic [1:0] kind,
    input  logic [7:0] sub_addr,
    input  logic [7:0] write_data,
    input  logic       sda_in,
    output bus_state_t nxt,
    output result_t    res
);

    function automatic logic [7:0] byte_to_send(input logic [1:0] idx, input bus_state_t s,
                                                input logic [6:0] addr7);
        logic [7:0] addr;
        addr = {addr7, 1'b0};
        if (idx == 2'd0) begin
            return addr;
        end else if (idx == 2'd1) begin
            return s.reg_latch;
        end else begin
            return s.is_read ? {addr7, 1'b1} : s.data_latch;
        end
    endfunction

    // Moves on once a byte's acknowledge slot is over.
    function automatic bus_state_t after_ack(input bus_state_t s, input logic [6:0] addr7);
        bus_state_t r;
        r = s;
        r.tick_count = '0;
        if (s.byte_index == 2'd0) begin
            r.byte_index = 2'd1;
            r.shift_byte = byte_to_send(2'd1, s, addr7);
            r.bit_index = '0;
            r.phase = PH_BIT_LO;
        end else if (s.byte_index == 2'd1) begin
            r.byte_index = 2'd2;
            if (s.is_read) begin
                r.phase = PH_RS_LO;
            end else begin
                r.shift_byte = byte_to_send(2'd2, s, addr7);
                r.bit_index = '0;
                r.phase = PH_BIT_LO;
            end
        end else if (s.is_read) begin
            r.shift_byte = '0;
            r.bit_index = '0;
            r.phase = PH_RD_LO;
        end else begin
            r.phase = PH_SP_LO;
        end
        return r;
    endfunction

    logic [TICK_W:0]   tick_inc;
    logic              phase_ends;
    logic [3:0]        bit_inc;
    logic [7:0]        rd_shift;
    logic              done;
    logic              rejected;

    assign tick_inc = {1'b0, cur.tick_count} + {{TICK_W{1'b0}}, 1'b1};
    assign phase_ends = tick_inc >= {1'b0, cfg.phase_ticks};
    assign bit_inc = cur.bit_index + 4'd1;
    assign rd_shift = {cur.shift_byte[6:0], sda_in};

    always_comb begin
        nxt = cur;
        done = 1'b0;
        rejected = 1'b0;
        if (kind == KIND_TICK) begin
            if (cur.phase == PH_ACK_WAIT) begin
                if (!sda_in) begin
                    nxt = after_ack(cur, cfg.slave_addr);
                end else if (tick_inc[TICK_W-1:0] >= cfg.ack_wait) begin
                    nxt.nack_seen = 1'b1;
                    nxt = after_ack(nxt, cfg.slave_addr);
                end else begin
                    nxt.tick_count = tick_inc[TICK_W-1:0];
                end
            end else if (cur.phase != PH_IDLE) begin
                if (!phase_ends) begin
                    nxt.tick_count = tick_inc[TICK_W-1:0];
                end else begin
                    nxt.tick_count = '0;
                    unique case (cur.phase)
                        PH_ST_HI: nxt.phase = PH_ST_LO;
                        PH_ST_LO: begin
                            nxt.shift_byte = byte_to_send(cur.byte_index, cur, cfg.slave_addr);
                            nxt.bit_index = '0;
                            nxt.phase = PH_BIT_LO;
                        end
                        PH_BIT_LO: nxt.phase = PH_BIT_HI;
                        PH_BIT_HI: begin
                            nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
                            nxt.bit_index = bit_inc;
                            nxt.phase = (bit_inc >= 4'd8) ? PH_ACK_LO : PH_BIT_LO;
                        end
                        PH_ACK_LO: nxt.phase = PH_ACK_HI;
                        PH_ACK_HI: nxt.phase = PH_ACK_WAIT;
                        PH_RS_LO:  nxt.phase = PH_ST_HI;
                        PH_RD_LO:  nxt.phase = PH_RD_HI;
                        PH_RD_HI: begin
                            nxt.shift_byte = rd_shift;
                            nxt.bit_index = bit_inc;
                            if (bit_inc >= 4'd8) begin
                                nxt.received_byte = rd_shift;
                                nxt.phase = PH_NK_LO;
                            end else begin
                                nxt.phase = PH_RD_LO;
                            end
                        end
                        PH_NK_LO: nxt.phase = PH_NK_HI;
                        PH_NK_HI: nxt.phase = PH_SP_LO;
                        PH_SP_LO: nxt.phase = PH_SP_HI;
                        PH_SP_HI: nxt.phase = PH_SP_REL;
                        PH_SP_REL: begin
                            nxt.phase = PH_IDLE;
                            done = 1'b1;
                        end
                        PH_IDLE, PH_ACK_WAIT: ;
                    endcase
                end
            end
        end else if (kind == KIND_WRITE || kind == KIND_READ) begin
            if (cur.phase != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                nxt.reg_latch = sub_addr;
                nxt.data_latch = write_data;
                nxt.is_read = (kind == KIND_READ);
                nxt.nack_seen = 1'b0;
                nxt.byte_index = '0;
                nxt.bit_index = '0;
                nxt.shift_byte = '0;
                nxt.tick_count = '0;
                nxt.phase = PH_ST_HI;
            end
        end
    end

    // Line levels follow the phase and shift register after the update.
    always_comb begin
        res.scl_level = 1'b1;
        res.sda_pull_low = 1'b0;
        unique case (nxt.phase)
            PH_ST_LO: res.sda_pull_low = 1'b1;
            PH_BIT_LO: begin
                res.scl_level = 1'b0;
                res.sda_pull_low = ~nxt.shift_byte[7];
            end
            PH_BIT_HI: res.sda_pull_low = ~nxt.shift_byte[7];
            PH_ACK_LO, PH_RS_LO, PH_RD_LO, PH_NK_LO: res.scl_level = 1'b0;
            PH_SP_LO: begin
                res.scl_level = 1'b0;
                res.sda_pull_low = 1'b1;
            end
            PH_SP_HI: res.sda_pull_low = 1'b1;
            PH_IDLE, PH_ST_HI, PH_ACK_HI, PH_ACK_WAIT, PH_RD_HI, PH_NK_HI, PH_SP_REL: ;
        endcase
        res.busy_res = (nxt.phase != PH_IDLE);
        res.done_res = done;
        res.read_byte = nxt.received_byte;
        res.ack_error = nxt.nack_seen;
        res.command_rejected = rejected;
    end

endmodule

// File: design/i2c_register_access_master.sv
// An accepted item passes through the input register and then the result register.
// One item per cycle while the result register is not stalled; the bus sequencer state updates once per item.
// A stalled result register holds its transfer while the input register still takes one item.
// Reset (aresetn low, synchronous): sequencer idle, result valid cleared, config at defaults.
// Configuration writes are taken in every cycle.
module i2c_register_access_master
    import i2cm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_kind,
    input  logic [7:0]             s_sub_addr,
    input  logic [7:0]             s_write_data,
    input  logic                   s_sda_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_scl_level,
    output logic                   m_sda_pull_low,
    output logic                   m_busy_res,
    output logic                   m_done_res,
    output logic [7:0]             m_read_byte,
    output logic                   m_ack_error,
    output logic                   m_command_rejected
);

    cfg_t       cfg;
    bus_state_t state_reg;
    bus_state_t state_next;
    result_t    res_next;
    result_t    res_reg;
    logic       in_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] sub_addr_reg;
    logic [7:0] write_data_reg;
    logic       sda_in_reg;
    logic       out_valid_reg;
    logic       advance;

    assign cfg_ready = 1'b1;

    i2cm_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The result register moves whenever it is empty or being drained.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            kind_reg <= s_kind;
            sub_addr_reg <= s_sub_addr;
            write_data_reg <= s_write_data;
            sda_in_reg <= s_sda_in;
        end
    end

    i2cm_step u_step (
        .cur         (state_reg),
        .cfg         (cfg),
        .kind        (kind_reg),
        .sub_addr    (sub_addr_reg),
        .write_data  (write_data_reg),
        .sda_in      (sda_in_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BUS_STATE_RST;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_scl_level = res_reg.scl_level;
    assign m_sda_pull_low = res_reg.sda_pull_low;
    assign m_busy_res = res_reg.busy_res;
    assign m_done_res = res_reg.done_res;
    assign m_read_byte = res_reg.read_byte;
    assign m_ack_error = res_reg.ack_error;
    assign m_command_rejected = res_reg.command_rejected;

endmodule

// File: design/i2cm_checker.sv
// Port-level checks for the I2C register access master, bound to the top level.
module i2cm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_scl_level,
    input logic       m_sda_pull_low,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic [7:0] m_read_byte,
    input logic       m_ack_error,
    input logic       m_command_rejected
);

    // A stalled result transfer keeps its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_byte) && $stable(m_busy_res)
            && $stable(m_scl_level) && $stable(m_sda_pull_low) && $stable(m_ack_error)
            && $stable(m_done_res) && $stable(m_command_rejected))
        else $error("result changed while stalled");

    // The STOP-complete pulse leaves the bus idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res && !m_command_rejected)
        else $error("done while still busy");

    // A command is only turned away during a transaction.
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_command_rejected |-> m_busy_res && !m_done_res)
        else $error("command rejected while idle");

    // An idle bus has both lines released.
    a_idle_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> m_scl_level && !m_sda_pull_low)
        else $error("lines driven while idle");

endmodule

bind i2c_register_access_master i2cm_checker u_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_scl_level        (m_scl_level),
    .m_sda_pull_low     (m_sda_pull_low),
    .m_busy_res         (m_busy_res),
    .m_done_res         (m_done_res),
    .m_read_byte        (m_read_byte),
    .m_ack_error        (m_ack_error),
    .m_command_rejected (m_command_rejected)
);

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the I2C register access master, with an item-level bus predictor.
module tb_top
    import i2cm_pkg::*;
();

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 8;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_kind = KIND_TICK;
    logic [7:0]             s_sub_addr = '0;
    logic [7:0]             s_write_data = '0;
    logic                   s_sda_in = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_scl_level;
    logic                   m_sda_pull_low;
    logic                   m_busy_res;
    logic                   m_done_res;
    logic [7:0]             m_read_byte;
    logic                   m_ack_error;
    logic                   m_command_rejected;

    i2c_register_access_master dut (.*);

    // Predicted sequencer state, starting at its reset values.
    phase_t      bus_ph = PH_IDLE;
    int unsigned tick_cnt = 0;
    logic [3:0]  bit_cnt = '0;
    logic [1:0]  byte_sel = '0;
    logic [7:0]  shifter = '0;
    logic [7:0]  reg_hold = '0;
    logic [7:0]  data_hold = '0;
    logic [7:0]  rx_byte = '0;
    logic        rd_mode = 1'b0;
    logic        nack_flag = 1'b0;
    logic [6:0]  cf_addr = SLAVE_ADDR_RST;
    int unsigned cf_phase_ticks = 32'(PHASE_TICKS_RST);
    int unsigned cf_ack_wait = 32'(ACK_WAIT_RST);

    result_t pending_res[$];
    result_t want_res;
    int      errors = 0;
    int      counted_items = 0;
    int      rx_wait = 0;
    bit      tx_idle_on = 1'b1;
    bit      rx_idle_on = 1'b1;
    bit      nack_mode = 1'b0;
    bit      hold_req = 1'b0;

    initial forever #1 aclk = ~aclk;

    function automatic logic [7:0] byte_out(logic [1:0] sel);
        if (sel == 2'd0) return {cf_addr, 1'b0};
        if (sel == 2'd1) return reg_hold;
        return rd_mode ? {cf_addr, 1'b1} : data_hold;
    endfunction

    function automatic void move_to(phase_t nxt);
        bus_ph = nxt;
        tick_cnt = 0;
    endfunction

    // Picks the next byte (after a repeated start in a read), the read or STOP once a byte's acknowledge slot is over.
    function automatic void byte_acked();
        if (byte_sel == 2'd0) begin
            byte_sel = 2'd1;
            shifter = byte_out(2'd1);
            bit_cnt = '0;
            move_to(PH_BIT_LO);
        end else if (byte_sel == 2'd1) begin
            byte_sel = 2'd2;
            if (rd_mode) begin
                move_to(PH_RS_LO);
            end else begin
                shifter = byte_out(2'd2);
                bit_cnt = '0;
                move_to(PH_BIT_LO);
            end
        end else if (rd_mode) begin
            shifter = '0;
            bit_cnt = '0;
            move_to(PH_RD_LO);
        end else begin
            move_to(PH_SP_LO);
        end
    endfunction

    function automatic result_t step_bus(logic [1:0] kind, logic [7:0] ra, logic [7:0] wd,
                                         logic sda);
        result_t res;
        logic    fin;
        logic    rej;
        logic    scl;
        logic    pull;
        fin = 1'b0;
        rej = 1'b0;
        if (kind == KIND_TICK) begin
            if (bus_ph == PH_ACK_WAIT) begin
                if (!sda) begin
                    byte_acked();
                end else begin
                    tick_cnt = (tick_cnt + 1) & 32'hFFFF;
                    if (tick_cnt >= cf_ack_wait) begin
                        nack_flag = 1'b1;
                        byte_acked();
                    end
                end
            end else if (bus_ph != PH_IDLE) begin
                if (tick_cnt + 1 < cf_phase_ticks) begin
                    tick_cnt = tick_cnt + 1;
                end else begin
                    case (bus_ph)
                        PH_ST_HI: move_to(PH_ST_LO);
                        PH_ST_LO: begin
                            shifter = byte_out(byte_sel);
                            bit_cnt = '0;
                            move_to(PH_BIT_LO);
                        end
                        PH_BIT_LO: move_to(PH_BIT_HI);
                        PH_BIT_HI: begin
                            shifter = {shifter[6:0], 1'b0};
                            bit_cnt = bit_cnt + 4'd1;
                            move_to(bit_cnt >= 8 ? PH_ACK_LO : PH_BIT_LO);
                        end
                        PH_ACK_LO: move_to(PH_ACK_HI);
                        PH_ACK_HI: move_to(PH_ACK_WAIT);
                        PH_RS_LO: move_to(PH_ST_HI);
                        PH_RD_LO: move_to(PH_RD_HI);
                        PH_RD_HI: begin
                            shifter = {shifter[6:0], sda};
                            bit_cnt = bit_cnt + 4'd1;
                            if (bit_cnt >= 8) begin
                                rx_byte = shifter;
                                move_to(PH_NK_LO);
                            end else begin
                                move_to(PH_RD_LO);
                            end
                        end
                        PH_NK_LO: move_to(PH_NK_HI);
                        PH_NK_HI: move_to(PH_SP_LO);
                        PH_SP_LO: move_to(PH_SP_HI);
                        PH_SP_HI: move_to(PH_SP_REL);
                        default: begin
                            move_to(PH_IDLE);
                            fin = 1'b1;
                        end
                    endcase
                end
            end
        end else if (kind == KIND_WRITE || kind == KIND_READ) begin
            if (bus_ph != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                reg_hold = ra;
                data_hold = wd;
                rd_mode = (kind == KIND_READ);
                nack_flag = 1'b0;
                byte_sel = '0;
                bit_cnt = '0;
                shifter = '0;
                move_to(PH_ST_HI);
            end
        end

        scl = 1'b1;
        pull = 1'b0;
        case (bus_ph)
            PH_ST_LO: pull = 1'b1;
            PH_BIT_LO: begin
                scl = 1'b0;
                pull = ~shifter[7];
            end
            PH_BIT_HI: pull = ~shifter[7];
            PH_ACK_LO, PH_RS_LO, PH_RD_LO, PH_NK_LO: scl = 1'b0;
            PH_SP_LO: begin
                scl = 1'b0;
                pull = 1'b1;
            end
            PH_SP_HI: pull = 1'b1;
            default: ;
        endcase

        res.scl_level = scl;
        res.sda_pull_low = pull;
        res.busy_res = (bus_ph != PH_IDLE);
        res.done_res = fin;
        res.read_byte = rx_byte;
        res.ack_error = nack_flag;
        res.command_rejected = rej;
        return res;
    endfunction

    // SDA as a slave would answer it: mostly ACK in the wait phase (always NACK in nack mode), random elsewhere.
    function automatic logic pick_sda();
        if (bus_ph != PH_ACK_WAIT) return 1'($urandom_range(0, 1));
        if (nack_mode) return 1'b1;
        return ($urandom_range(0, 99) < 85) ? 1'b0 : 1'b1;
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [7:0] ra, input logic [7:0] wd,
                             input logic sda);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_sub_addr <= ra;
        s_write_data <= wd;
        s_sda_in <= sda;
        do @(posedge aclk); while (!s_ready);
        // Ticks while idle and kind three items do nothing, so they are not counted.
        if (kind != KIND_NONE && !(kind == KIND_TICK && bus_ph == PH_IDLE))
            counted_items++;
        pending_res.push_back(step_bus(kind, ra, wd, sda));
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_res.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SLAVE_ADDR: cf_addr = val[6:0];
            CFG_PHASE_TICKS: cf_phase_ticks = 32'(val);
            CFG_ACK_WAIT: cf_ack_wait = 32'(val);
            default: ;
        endcase
    endtask

    // One command, then ticks until STOP completes; noise is the percentage of stray items.
    task automatic run_transfer(input logic [1:0] kind, input logic [7:0] ra, input logic [7:0] wd,
                                input bit nack, input int noise);
        nack_mode = nack;
        send_item(kind, ra, wd, 1'($urandom_range(0, 1)));
        while (bus_ph != PH_IDLE) begin
            if ($urandom_range(0, 99) < noise)
                send_item(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                          1'($urandom_range(0, 1)));
            else
                send_item(KIND_TICK, 8'($urandom), 8'($urandom), pick_sda());
        end
        nack_mode = 1'b0;
    endtask

    task automatic test_defaults();
        send_item(KIND_TICK, 8'h00, 8'h00, 1'b0);
        send_item(KIND_TICK, 8'hFF, 8'hFF, 1'b1);
        send_item(KIND_NONE, 8'hFF, 8'hFF, 1'b1);
        run_transfer(KIND_WRITE, 8'hFF, 8'h00, 1'b0, 0);
        wait_results();
    endtask

    task automatic test_settings();
        write_reg(CFG_PHASE_TICKS, 16'd1);
        write_reg(CFG_SLAVE_ADDR, 16'h007F);
        run_transfer(KIND_WRITE, 8'h00, 8'hFF, 1'b0, 0);
        run_transfer(KIND_READ, 8'hFF, 8'h00, 1'b0, 0);
        wait_results();
        // Only the low seven bits hold the address, so this one is zero.
        write_reg(CFG_SLAVE_ADDR, 16'hFF80);
        run_transfer(KIND_READ, 8'h5A, 8'hA5, 1'b0, 0);
        wait_results();
    endtask

    task automatic test_nack();
        write_reg(CFG_ACK_WAIT, 16'd0);
        run_transfer(KIND_WRITE, 8'($urandom), 8'($urandom), 1'b1, 0);
        run_transfer(KIND_READ, 8'($urandom), 8'($urandom), 1'b1, 0);
        wait_results();
        write_reg(CFG_ACK_WAIT, 16'd3);
        run_transfer(KIND_READ, 8'($urandom), 8'($urandom), 1'b1, 0);
        // The error flag must clear when this command is taken.
        run_transfer(KIND_WRITE, 8'($urandom), 8'($urandom), 1'b0, 0);
        wait_results();
    endtask

    task automatic test_busy_commands();
        write_reg(CFG_ACK_WAIT, 16'd2);
        write_reg(CFG_UNUSED, 16'hFFFF);
        run_transfer(KIND_WRITE, 8'($urandom), 8'($urandom), 1'b0, 30);
        run_transfer(KIND_READ, 8'($urandom), 8'($urandom), 1'b0, 30);
        wait_results();
    endtask

    task automatic test_phase_extremes();
        write_reg(CFG_PHASE_TICKS, 16'd0);
        write_reg(CFG_ACK_WAIT, 16'hFFFF);
        run_transfer(KIND_READ, 8'($urandom), 8'($urandom), 1'b0, 0);
        run_transfer(KIND_WRITE, 8'($urandom), 8'($urandom), 1'b0, 0);
        wait_results();
        // A whole transfer at the longest phase would take millions of ticks.
        write_reg(CFG_PHASE_TICKS, 16'hFFFF);
        send_item(KIND_TICK, 8'($urandom), 8'($urandom), 1'b1);
        send_item(KIND_NONE, 8'($urandom), 8'($urandom), 1'b0);
        wait_results();
        write_reg(CFG_PHASE_TICKS, 16'd2);
        write_reg(CFG_ACK_WAIT, 16'd1);
        run_transfer(KIND_WRITE, 8'($urandom), 8'($urandom), 1'b1, 0);
        wait_results();
    endtask

    task automatic test_backpressure();
        // The sink stops for a long stretch while items keep coming back to back.
        tx_idle_on = 1'b0;
        hold_req = 1'b1;
        run_transfer(KIND_READ, 8'($urandom), 8'($urandom), 1'b0, 0);
        wait_results();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random();
        int         target;
        logic [15:0] pv;
        logic [15:0] av;
        bit          nack;
        target = counted_items + RANDOM_ITEMS;
        while (counted_items < target) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) begin
                wait_results();
                case ($urandom_range(0, 9))
                    0: pv = 16'd0;
                    6, 7: pv = 16'd2;
                    8: pv = 16'd3;
                    9: pv = 16'($urandom_range(4, 6));
                    default: pv = 16'd1;
                endcase
                case ($urandom_range(0, 7))
                    0: av = 16'd0;
                    1: av = 16'd1;
                    2: av = 16'd2;
                    3: av = 16'd5;
                    4: av = 16'd16;
                    5: av = 16'd688;
                    6: av = 16'hFFFF;
                    default: av = 16'($urandom);
                endcase
                write_reg(CFG_SLAVE_ADDR, 16'($urandom));
                write_reg(CFG_PHASE_TICKS, pv);
                write_reg(CFG_ACK_WAIT, av);
            end
            if ($urandom_range(0, 19) == 0) hold_req = 1'b1;
            nack = (cf_ack_wait <= 16) && ($urandom_range(0, 4) == 0);
            run_transfer($urandom_range(0, 1) ? KIND_READ : KIND_WRITE, 8'($urandom),
                         8'($urandom), nack, 4);
            if ($urandom_range(0, 3) == 0)
                send_item($urandom_range(0, 1) ? KIND_TICK : KIND_NONE, 8'($urandom),
                          8'($urandom), 1'($urandom_range(0, 1)));
        end
        wait_results();
    endtask

    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready)
                rx_wait = rx_idle_on ? $urandom_range(0, 12) : 0;
            if (hold_req) begin
                rx_wait = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_res.size() == 0) begin
                errors++;
                $display("%0t: result transfer with nothing expected, read_byte %0h",
                         $time, m_read_byte);
            end else begin
                want_res = pending_res.pop_front();
                check_field("scl_level", 8'(want_res.scl_level), 8'(m_scl_level));
                check_field("sda_pull_low", 8'(want_res.sda_pull_low), 8'(m_sda_pull_low));
                check_field("busy_res", 8'(want_res.busy_res), 8'(m_busy_res));
                check_field("done_res", 8'(want_res.done_res), 8'(m_done_res));
                check_field("read_byte", want_res.read_byte, m_read_byte);
                check_field("ack_error", 8'(want_res.ack_error), 8'(m_ack_error));
                check_field("command_rejected", 8'(want_res.command_rejected),
                            8'(m_command_rejected));
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Verification failed");
        $finish;
    end

    initial begin : main_seq
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_defaults();
        test_settings();
        test_nack();
        test_busy_commands();
        test_phase_extremes();
        test_backpressure();
        test_random();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: i2c_register_access_master.f
design/i2cm_pkg.sv
design/i2cm_regs.sv
design/i2cm_step.sv
design/i2c_register_access_master.sv
design/i2cm_checker.sv
verif/tb_top.sv
